FILE: src/pixel_heat_smooth_colorize_assert.svh
// assertion macros shared by the pixel heat smoothing and colorizing block
// no dependencies; included by the modules that carry assertions
`ifndef PIXEL_HEAT_SMOOTH_COLORIZE_ASSERT_SVH
`define PIXEL_HEAT_SMOOTH_COLORIZE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PHSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PHSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PHSC_ASSERT(lbl, clk, rst_n, prop)
`define PHSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/phsc_pkg.sv
// package for the pixel heat smoothing and colorizing block
// types, constants and arithmetic helpers; no dependencies
`timescale 1ns / 1ps

package phsc_pkg;

  localparam int PIXELS = 1024;
  localparam int LVL_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int IDX_W  = 10;
  localparam int LVL_W  = 8;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [2:0] REG_KEEP_WEIGHT = 3'd0;
  localparam logic [2:0] REG_MAX_RISE    = 3'd1;
  localparam logic [2:0] REG_MAX_FALL    = 3'd2;
  localparam logic [2:0] REG_BG_HEAT     = 3'd3;
  localparam logic [2:0] REG_WHITE_HOT   = 3'd4;
  localparam logic [2:0] REG_BASE_COLOR  = 3'd5;
  localparam logic [2:0] REG_NIGHT_MODE  = 3'd6;
  localparam logic [2:0] REG_BRIGHTNESS  = 3'd7;

  localparam logic [7:0]  RST_KEEP_WEIGHT = 8'd172;
  localparam logic [5:0]  RST_MAX_RISE    = 6'd26;
  localparam logic [5:0]  RST_MAX_FALL    = 6'd22;
  localparam logic [6:0]  RST_BG_HEAT     = 7'd10;
  localparam logic [6:0]  RST_WHITE_HOT   = 7'd20;
  localparam logic [23:0] RST_BASE_COLOR  = 24'hFF4D00;
  localparam logic        RST_NIGHT_MODE  = 1'b0;
  localparam logic [7:0]  RST_BRIGHTNESS  = 8'd255;

  localparam logic [7:0]  FULL_SCALE  = 8'd255;
  localparam logic [1:0]  NIGHT_GAIN  = 2'd3;
  localparam logic [7:0]  NIGHT_FLOOR = 8'd16;
  localparam logic [7:0]  CAP_MIN     = 8'd20;
  localparam logic [7:0]  CAP_MAX     = 8'd60;
  // products at or above this value give a quotient by 255 of at least 256
  localparam logic [16:0] DIV_SAT     = 17'd65280;

  typedef struct packed {
    logic [7:0]  keep_weight;
    logic [5:0]  max_rise_step;
    logic [5:0]  max_fall_step;
    logic [6:0]  background_heat;
    logic [6:0]  white_hot_amount;
    logic [23:0] base_color;
    logic        night_mode;
    logic [7:0]  brightness;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [LVL_AW-1:0] addr;
  } lvl_rd_t;

  typedef struct packed {
    logic              en;
    logic [LVL_AW-1:0] addr;
    logic [LVL_W-1:0]  data;
  } lvl_wr_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] level;
    logic [7:0]       flick;
  } pix_t;

  // floor(x / 255), exact for x below 65280
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'd1 + 17'(x[15:8]);
    return s[15:8];
  endfunction

endpackage

FILE: src/pixel_heat_smooth_colorize.sv
// channel      | handshake             | payload
// config (APB) | psel penable pready   | paddr pwdata prdata
// pixel in     | in_valid_i in_stall_o | pixel_index_i glow_heat_i flicker_factor_i
// color out    | out_valid_o out_stall_i | out_index_o out_red_o out_green_o out_blue_o
//
// one transaction per cycle sustained unless the output stalls or the store clears
// the level store is read on acceptance; blend and write-back use the registered read, with forwarding
// after reset the level store clears all PIXELS entries with input stalled
// a stalled output freezes the whole pipeline and stalls the input
// top level: config registers and APB port; uses phsc_pkg, phsc_store,
// phsc_blend, phsc_color
`timescale 1ns / 1ps
`include "pixel_heat_smooth_colorize_assert.svh"

module pixel_heat_smooth_colorize (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [phsc_pkg::APB_AW-1:0]   paddr,
  input  logic [phsc_pkg::APB_DW-1:0]   pwdata,
  output logic [phsc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [phsc_pkg::IDX_W-1:0]    pixel_index_i,
  input  logic [7:0]                    glow_heat_i,
  input  logic [7:0]                    flicker_factor_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [phsc_pkg::IDX_W-1:0]    out_index_o,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o
);

  phsc_pkg::cfg_t    cfg_q;
  logic              cfg_we;
  logic [2:0]        reg_sel;
  logic              adv;
  logic              accept;
  logic              clearing;
  phsc_pkg::lvl_rd_t lvl_rd;
  phsc_pkg::lvl_wr_t lvl_wr;
  logic [phsc_pkg::LVL_W-1:0] lvl_rdata;
  phsc_pkg::pix_t    pix;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keep_weight      <= phsc_pkg::RST_KEEP_WEIGHT;
      cfg_q.max_rise_step    <= phsc_pkg::RST_MAX_RISE;
      cfg_q.max_fall_step    <= phsc_pkg::RST_MAX_FALL;
      cfg_q.background_heat  <= phsc_pkg::RST_BG_HEAT;
      cfg_q.white_hot_amount <= phsc_pkg::RST_WHITE_HOT;
      cfg_q.base_color       <= phsc_pkg::RST_BASE_COLOR;
      cfg_q.night_mode       <= phsc_pkg::RST_NIGHT_MODE;
      cfg_q.brightness       <= phsc_pkg::RST_BRIGHTNESS;
    end else if (cfg_we) begin
      unique case (reg_sel)
        phsc_pkg::REG_KEEP_WEIGHT: cfg_q.keep_weight      <= pwdata[7:0];
        phsc_pkg::REG_MAX_RISE:    cfg_q.max_rise_step    <= pwdata[5:0];
        phsc_pkg::REG_MAX_FALL:    cfg_q.max_fall_step    <= pwdata[5:0];
        phsc_pkg::REG_BG_HEAT:     cfg_q.background_heat  <= pwdata[6:0];
        phsc_pkg::REG_WHITE_HOT:   cfg_q.white_hot_amount <= pwdata[6:0];
        phsc_pkg::REG_BASE_COLOR:  cfg_q.base_color       <= pwdata[23:0];
        phsc_pkg::REG_NIGHT_MODE:  cfg_q.night_mode       <= pwdata[0];
        phsc_pkg::REG_BRIGHTNESS:  cfg_q.brightness       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      phsc_pkg::REG_KEEP_WEIGHT: prdata = 32'(cfg_q.keep_weight);
      phsc_pkg::REG_MAX_RISE:    prdata = 32'(cfg_q.max_rise_step);
      phsc_pkg::REG_MAX_FALL:    prdata = 32'(cfg_q.max_fall_step);
      phsc_pkg::REG_BG_HEAT:     prdata = 32'(cfg_q.background_heat);
      phsc_pkg::REG_WHITE_HOT:   prdata = 32'(cfg_q.white_hot_amount);
      phsc_pkg::REG_BASE_COLOR:  prdata = 32'(cfg_q.base_color);
      phsc_pkg::REG_NIGHT_MODE:  prdata = 32'(cfg_q.night_mode);
      phsc_pkg::REG_BRIGHTNESS:  prdata = 32'(cfg_q.brightness);
      default:                   prdata = '0;
    endcase
  end

  // pipeline moves when the output register is free or being taken
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = clearing || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  phsc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (lvl_rd),
    .wr_i      (lvl_wr),
    .rd_data_o (lvl_rdata),
    .busy_o    (clearing)
  );

  phsc_blend u_blend (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .accept_i         (accept),
    .adv_i            (adv),
    .pixel_index_i    (pixel_index_i),
    .glow_heat_i      (glow_heat_i),
    .flicker_factor_i (flicker_factor_i),
    .rd_data_i        (lvl_rdata),
    .rd_o             (lvl_rd),
    .wr_o             (lvl_wr),
    .pix_o            (pix)
  );

  phsc_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .adv_i       (adv),
    .pix_i       (pix),
    .out_valid_o (out_valid_o),
    .out_index_o (out_index_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

  `PHSC_ASSERT(a_no_accept_in_clear, clk_i, rst_ni, accept |-> !clearing)

endmodule

FILE: src/phsc_store.sv
// level store: one synchronous memory of previous levels per pixel
// clears itself after reset; uses phsc_pkg
`timescale 1ns / 1ps
`include "pixel_heat_smooth_colorize_assert.svh"

module phsc_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  phsc_pkg::lvl_rd_t          rd_i,
  input  phsc_pkg::lvl_wr_t          wr_i,
  output logic [phsc_pkg::LVL_W-1:0] rd_data_o,
  output logic                       busy_o
);

  localparam logic [phsc_pkg::LVL_AW-1:0] LAST_ADDR =
    phsc_pkg::LVL_AW'(phsc_pkg::PIXELS - 1);

  logic [phsc_pkg::LVL_W-1:0]  lvl_mem_q [phsc_pkg::PIXELS];
  logic [phsc_pkg::LVL_W-1:0]  rd_data_q;
  logic [phsc_pkg::LVL_AW-1:0] clr_addr_q, clr_addr_d;
  logic                        busy_q, busy_d;
  logic                        we;
  logic [phsc_pkg::LVL_AW-1:0] waddr;
  logic [phsc_pkg::LVL_W-1:0]  wdata;

  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + phsc_pkg::LVL_AW'(1);
      if (clr_addr_q == LAST_ADDR) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
    end
  end

  // clearing pass owns the write port
  assign we    = busy_q | wr_i.en;
  assign waddr = busy_q ? clr_addr_q : wr_i.addr;
  assign wdata = busy_q ? '0 : wr_i.data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      lvl_mem_q[waddr] <= wdata;
    end
    if (rd_i.en) begin
      rd_data_q <= lvl_mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

  `PHSC_ASSERT(a_no_read_in_clear, clk_i, rst_ni, rd_i.en |-> !busy_q)
  `PHSC_ASSERT_NEXT(a_clear_ends, clk_i, rst_ni, busy_q && clr_addr_q == LAST_ADDR, !busy_q)

endmodule

FILE: src/phsc_blend.sv
// blend stage: temporal blend of heat with the stored level, step limits,
// forwarding of a same-pixel write, write-back request; uses phsc_pkg
`timescale 1ns / 1ps
`include "pixel_heat_smooth_colorize_assert.svh"

module phsc_blend (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  phsc_pkg::cfg_t             cfg_i,
  input  logic                       accept_i,
  input  logic                       adv_i,
  input  logic [phsc_pkg::IDX_W-1:0] pixel_index_i,
  input  logic [7:0]                 glow_heat_i,
  input  logic [7:0]                 flicker_factor_i,
  input  logic [phsc_pkg::LVL_W-1:0] rd_data_i,
  output phsc_pkg::lvl_rd_t          rd_o,
  output phsc_pkg::lvl_wr_t          wr_o,
  output phsc_pkg::pix_t             pix_o
);

  logic                       v1_q, v1_d;
  logic [phsc_pkg::IDX_W-1:0] idx1_q;
  logic [7:0]                 heat1_q;
  logic [7:0]                 flick1_q;
  logic                       in_store1_q;
  logic                       fwd_hit_q, fwd_hit_d;
  logic [phsc_pkg::LVL_W-1:0] fwd_lvl_q;
  logic                       new_in_store;

  logic [7:0]         prev;
  logic [8:0]         desired_sum;
  logic [7:0]         desired;
  logic [15:0]        base16;
  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic signed [17:0] blend;
  logic [7:0]         level_raw;
  logic [8:0]         rise_lim;
  logic [7:0]         level;

  assign new_in_store = 32'(pixel_index_i) < phsc_pkg::PIXELS;

  always_comb begin
    v1_d      = v1_q;
    fwd_hit_d = fwd_hit_q;
    if (accept_i) begin
      v1_d      = 1'b1;
      fwd_hit_d = v1_q && in_store1_q && new_in_store && (idx1_q == pixel_index_i);
    end else if (adv_i) begin
      v1_d      = 1'b0;
      fwd_hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      v1_q      <= v1_d;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      idx1_q      <= pixel_index_i;
      heat1_q     <= glow_heat_i;
      flick1_q    <= flicker_factor_i;
      in_store1_q <= new_in_store;
      fwd_lvl_q   <= level;
    end
  end

  always_comb begin
    if (!in_store1_q) begin
      prev = '0;
    end else if (fwd_hit_q) begin
      prev = fwd_lvl_q;
    end else begin
      prev = rd_data_i;
    end

    desired_sum = 9'(heat1_q) + 9'(cfg_i.background_heat);
    desired     = (desired_sum > 9'(phsc_pkg::FULL_SCALE)) ? phsc_pkg::FULL_SCALE
                                                           : desired_sum[7:0];

    // prev*k + d*(255-k) rewritten as d*255 + (prev-d)*k
    base16    = {desired, 8'h00} - 16'(desired);
    diff      = $signed({1'b0, prev}) - $signed({1'b0, desired});
    prod      = diff * $signed({1'b0, cfg_i.keep_weight});
    blend     = $signed({2'b00, base16}) + prod;
    level_raw = phsc_pkg::div255(blend[15:0]);

    rise_lim = 9'(prev) + 9'(cfg_i.max_rise_step);
    level    = level_raw;
    if (level_raw > prev) begin
      if (9'(level_raw) > rise_lim) begin
        level = rise_lim[7:0];
      end
    end else if (level_raw < prev) begin
      if (prev >= 8'(cfg_i.max_fall_step) && level_raw < prev - 8'(cfg_i.max_fall_step)) begin
        level = prev - 8'(cfg_i.max_fall_step);
      end
    end
  end

  assign rd_o.en   = accept_i;
  assign rd_o.addr = phsc_pkg::LVL_AW'(pixel_index_i);

  assign wr_o.en   = v1_q && adv_i && in_store1_q;
  assign wr_o.addr = phsc_pkg::LVL_AW'(idx1_q);
  assign wr_o.data = level;

  assign pix_o.valid = v1_q;
  assign pix_o.idx   = idx1_q;
  assign pix_o.level = level;
  assign pix_o.flick = flick1_q;

  `PHSC_ASSERT(a_fwd_needs_item, clk_i, rst_ni, fwd_hit_q |-> v1_q && in_store1_q)
  `PHSC_ASSERT_NEXT(a_stall_holds_s1, clk_i, rst_ni, v1_q && !adv_i, v1_q && $stable(idx1_q))

endmodule

FILE: src/phsc_color.sv
// colorize pipeline: flicker, night or brightness scaling, white-hot add,
// per-channel scaling and night cap, output register; uses phsc_pkg
`timescale 1ns / 1ps

module phsc_color (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  phsc_pkg::cfg_t             cfg_i,
  input  logic                       adv_i,
  input  phsc_pkg::pix_t             pix_i,
  output logic                       out_valid_o,
  output logic [phsc_pkg::IDX_W-1:0] out_index_o,
  output logic [7:0]                 out_red_o,
  output logic [7:0]                 out_green_o,
  output logic [7:0]                 out_blue_o
);

  localparam int NST = 6;

  logic [NST-1:0]                    vpipe_q;
  logic                              out_valid_q;
  logic [NST-1:0][phsc_pkg::IDX_W-1:0] idx_q;
  logic [phsc_pkg::IDX_W-1:0]        out_idx_q;

  logic [7:0]        level2_q, flick2_q;
  logic [7:0]        lv3_q;
  logic [7:0]        lv4_q;
  logic [7:0]        lv5_q, w5_q;
  logic [2:0][16:0]  prod6_q;
  logic [2:0][7:0]   c7_q;
  logic [2:0][7:0]   rgb_q;

  logic [7:0]        lv1_d;
  logic [9:0]        boost;
  logic [7:0]        night_lv;
  logic [7:0]        lv4_d;
  logic [7:0]        w5_d;
  logic [2:0][7:0]   base_ch;
  logic [2:0][16:0]  prod6_d;
  logic [2:0][7:0]   c7_d;
  logic [8:0]        cap_p1;
  logic [2:0][7:0]   rgb_d;

  function automatic logic [7:0] scale8(logic [7:0] a, logic [7:0] b);
    logic [16:0] p;
    p = 17'(a) * 17'({1'b0, b} + 9'd1);
    return p[15:8];
  endfunction

  assign base_ch[0] = cfg_i.base_color[23:16];
  assign base_ch[1] = cfg_i.base_color[15:8];
  assign base_ch[2] = cfg_i.base_color[7:0];

  always_comb begin
    lv1_d = scale8(level2_q, flick2_q);

    boost    = 10'(lv3_q) * 10'(phsc_pkg::NIGHT_GAIN);
    night_lv = (boost > 10'(phsc_pkg::FULL_SCALE)) ? phsc_pkg::FULL_SCALE : boost[7:0];
    if (night_lv != 8'd0 && night_lv < phsc_pkg::NIGHT_FLOOR) begin
      night_lv = phsc_pkg::NIGHT_FLOOR;
    end
    lv4_d = cfg_i.night_mode ? night_lv : scale8(lv3_q, cfg_i.brightness);

    w5_d = scale8(lv4_q, 8'(cfg_i.white_hot_amount));

    cap_p1 = (cfg_i.brightness >= phsc_pkg::CAP_MAX - phsc_pkg::CAP_MIN)
             ? 9'(phsc_pkg::CAP_MAX) + 9'd1
             : 9'(cfg_i.brightness) + 9'(phsc_pkg::CAP_MIN) + 9'd1;

    for (int k = 0; k < 3; k++) begin
      prod6_d[k] = (17'(base_ch[k]) + 17'(w5_q)) * 17'(lv5_q);
      c7_d[k]    = (prod6_q[k] >= phsc_pkg::DIV_SAT) ? phsc_pkg::FULL_SCALE
                                                     : phsc_pkg::div255(prod6_q[k][15:0]);
      rgb_d[k]   = cfg_i.night_mode ? 8'((17'(c7_q[k]) * 17'(cap_p1)) >> 8) : c7_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      vpipe_q     <= {vpipe_q[NST-2:0], pix_i.valid};
      out_valid_q <= vpipe_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q     <= {idx_q[NST-2:0], pix_i.idx};
      out_idx_q <= idx_q[NST-1];
      level2_q  <= pix_i.level;
      flick2_q  <= pix_i.flick;
      lv3_q     <= lv1_d;
      lv4_q     <= lv4_d;
      lv5_q     <= lv4_q;
      w5_q      <= w5_d;
      prod6_q   <= prod6_d;
      c7_q      <= c7_d;
      rgb_q     <= rgb_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_idx_q;
  assign out_red_o   = rgb_q[0];
  assign out_green_o = rgb_q[1];
  assign out_blue_o  = rgb_q[2];

endmodule

FILE: test/tb.sv
// testbench for pixel_heat_smooth_colorize: pixel transactions are checked against a
// behavioral model of the level smoothing and colorizing, config is changed over APB
// depends on phsc_pkg and the pixel_heat_smooth_colorize RTL
`timescale 1ns / 1ps

module tb;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int LONG_HOLD    = 120;
  localparam int BURST_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_REGS     = 8;

  typedef struct packed {
    logic [phsc_pkg::IDX_W-1:0] idx;
    logic [7:0]                 heat;
    logic [7:0]                 flick;
    logic                       typed;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
  } pixel_req_t;

  typedef struct packed {
    logic [phsc_pkg::IDX_W-1:0] idx;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
  } pixel_color_t;

  // probe pixels under reset config, so colors follow directly from the formulas
  localparam pixel_req_t PROBE_ROWS [20] = '{
    '{10'd0,    8'd255, 8'd255, 1'b1, 8'd26, 8'd8, 8'd0},
    '{10'd1023, 8'd0,   8'd255, 1'b1, 8'd3,  8'd0, 8'd0},
    '{10'd5,    8'd255, 8'd0,   1'b1, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd255, 8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd255, 8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd255, 8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd255, 8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd255, 8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd0,   8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd0,   8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd0,   8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd0,   8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd1023, 8'd255, 8'd128, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd512,  8'd128, 8'd1,   1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd512,  8'd128, 8'd254, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd341,  8'd170, 8'd85,  1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd682,  8'd85,  8'd170, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd1023, 8'd255, 8'd255, 1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd0,    8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 8'd0},
    '{10'd1,    8'd1,   8'd255, 1'b0, 8'd0,  8'd0, 8'd0}
  };

  localparam logic [phsc_pkg::IDX_W-1:0] HOT_PIXELS [8] = '{
    10'd0, 10'd1, 10'd2, 10'd511, 10'd512, 10'd1021, 10'd1022, 10'd1023
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [phsc_pkg::APB_AW-1:0]   paddr;
  logic [phsc_pkg::APB_DW-1:0]   pwdata;
  logic [phsc_pkg::APB_DW-1:0]   prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [phsc_pkg::IDX_W-1:0]    pixel_index_i;
  logic [7:0]                    glow_heat_i;
  logic [7:0]                    flicker_factor_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [phsc_pkg::IDX_W-1:0]    out_index_o;
  logic [7:0]                    out_red_o;
  logic [7:0]                    out_green_o;
  logic [7:0]                    out_blue_o;

  phsc_pkg::cfg_t                knobs;
  logic [phsc_pkg::LVL_W-1:0]    heat_level [phsc_pkg::PIXELS];
  pixel_color_t                  color_due [$];
  int                            errors;
  int                            cycle_count;
  logic                          tx_quiet;
  logic                          rx_quiet;
  logic                          long_hold_req;
  int                            burst_left;

  pixel_heat_smooth_colorize dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_index_i    (pixel_index_i),
    .glow_heat_i      (glow_heat_i),
    .flicker_factor_i (flicker_factor_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_index_o      (out_index_o),
    .out_red_o        (out_red_o),
    .out_green_o      (out_green_o),
    .out_blue_o       (out_blue_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic int frac8(int a, int b);
    return (a * (b + 1)) >> 8;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // smooths the stored level of one pixel, writes it back and colors it
  function automatic pixel_color_t color_pixel(logic [phsc_pkg::IDX_W-1:0] idx,
                                               logic [7:0] heat, logic [7:0] flick);
    pixel_color_t res;
    int full, kw, prev, want, lvl, lv, w, c, cap;
    int base [3];
    int chan [3];
    logic in_store;
    full = int'(phsc_pkg::FULL_SCALE);
    kw   = int'(knobs.keep_weight);
    // pixels beyond the store start from zero and are not written back
    in_store = int'(idx) < phsc_pkg::PIXELS;
    prev = in_store ? int'(heat_level[idx]) : 0;
    want = int'(heat) + int'(knobs.background_heat);
    if (want > full) want = full;
    lvl = (prev * kw + want * (full - kw)) / full;
    if (lvl > prev) begin
      if (lvl > prev + int'(knobs.max_rise_step)) lvl = prev + int'(knobs.max_rise_step);
    end else if (lvl < prev) begin
      if (prev >= int'(knobs.max_fall_step) && lvl < prev - int'(knobs.max_fall_step))
        lvl = prev - int'(knobs.max_fall_step);
    end
    if (in_store) heat_level[idx] = 8'(lvl);
    res = '{idx, 8'd0, 8'd0, 8'd0};
    if (lvl == 0) return res;
    lv = frac8(lvl, int'(flick));
    if (knobs.night_mode) begin
      lv = lv * int'(phsc_pkg::NIGHT_GAIN);
      if (lv > full) lv = full;
      if (lv > 0 && lv < int'(phsc_pkg::NIGHT_FLOOR)) lv = int'(phsc_pkg::NIGHT_FLOOR);
    end else begin
      lv = frac8(lv, int'(knobs.brightness));
    end
    w = (knobs.white_hot_amount != 0) ? frac8(lv, int'(knobs.white_hot_amount)) : 0;
    cap = int'(knobs.brightness) + int'(phsc_pkg::CAP_MIN);
    if (cap > int'(phsc_pkg::CAP_MAX)) cap = int'(phsc_pkg::CAP_MAX);
    base[0] = int'(knobs.base_color[23:16]);
    base[1] = int'(knobs.base_color[15:8]);
    base[2] = int'(knobs.base_color[7:0]);
    for (int k = 0; k < 3; k++) begin
      c = (base[k] + w) * lv / full;
      if (c > full) c = full;
      if (knobs.night_mode) c = frac8(c, cap);
      chan[k] = c;
    end
    res.red   = 8'(chan[0]);
    res.green = 8'(chan[1]);
    res.blue  = 8'(chan[2]);
    return res;
  endfunction

  function automatic logic [31:0] knob_value(logic [2:0] r);
    case (r)
      phsc_pkg::REG_KEEP_WEIGHT: return 32'(knobs.keep_weight);
      phsc_pkg::REG_MAX_RISE:    return 32'(knobs.max_rise_step);
      phsc_pkg::REG_MAX_FALL:    return 32'(knobs.max_fall_step);
      phsc_pkg::REG_BG_HEAT:     return 32'(knobs.background_heat);
      phsc_pkg::REG_WHITE_HOT:   return 32'(knobs.white_hot_amount);
      phsc_pkg::REG_BASE_COLOR:  return 32'(knobs.base_color);
      phsc_pkg::REG_NIGHT_MODE:  return 32'(knobs.night_mode);
      default:                   return 32'(knobs.brightness);
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (tx_quiet || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic pixel_req_t random_req();
    pixel_req_t req;
    int roll;
    req = '0;
    if ($urandom_range(99, 0) < 65) req.idx = HOT_PIXELS[$urandom_range(7, 0)];
    else req.idx = phsc_pkg::IDX_W'($urandom_range(phsc_pkg::PIXELS - 1, 0));
    roll = $urandom_range(99, 0);
    if (roll < 20) req.heat = 8'd0;
    else if (roll < 40) req.heat = 8'd255;
    else req.heat = 8'($urandom_range(255, 0));
    roll = $urandom_range(99, 0);
    if (roll < 15) req.flick = 8'd255;
    else if (roll < 25) req.flick = 8'd0;
    else req.flick = 8'($urandom_range(255, 0));
    return req;
  endfunction

  // apb tasks leave psel and penable high; the caller releases the bus
  task automatic apb_write(logic [2:0] r, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apb_read(logic [2:0] r, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
  endtask

  task automatic write_knob(logic [2:0] r, logic [31:0] val);
    logic [31:0] rd;
    apb_write(r, val);
    case (r)
      phsc_pkg::REG_KEEP_WEIGHT: knobs.keep_weight      = val[7:0];
      phsc_pkg::REG_MAX_RISE:    knobs.max_rise_step    = val[5:0];
      phsc_pkg::REG_MAX_FALL:    knobs.max_fall_step    = val[5:0];
      phsc_pkg::REG_BG_HEAT:     knobs.background_heat  = val[6:0];
      phsc_pkg::REG_WHITE_HOT:   knobs.white_hot_amount = val[6:0];
      phsc_pkg::REG_BASE_COLOR:  knobs.base_color       = val[23:0];
      phsc_pkg::REG_NIGHT_MODE:  knobs.night_mode       = val[0];
      default:                   knobs.brightness       = val[7:0];
    endcase
    apb_read(r, rd);
    check_field($sformatf("register %0d", r), int'(knob_value(r)), int'(rd));
  endtask

  task automatic program_phase(int p);
    logic [31:0] v [NUM_REGS];
    v[phsc_pkg::REG_KEEP_WEIGHT] = $urandom_range(210, 130);
    v[phsc_pkg::REG_MAX_RISE]    = $urandom_range(62, 6);
    v[phsc_pkg::REG_MAX_FALL]    = $urandom_range(52, 5);
    v[phsc_pkg::REG_BG_HEAT]     = $urandom_range(100, 0);
    v[phsc_pkg::REG_WHITE_HOT]   = $urandom_range(100, 0);
    v[phsc_pkg::REG_BASE_COLOR]  = 32'($urandom_range(24'hFFFFFF, 0));
    v[phsc_pkg::REG_NIGHT_MODE]  = $urandom_range(1, 0);
    v[phsc_pkg::REG_BRIGHTNESS]  = $urandom_range(255, 0);
    case (p)
      0: begin
        v[phsc_pkg::REG_KEEP_WEIGHT] = 0;
        v[phsc_pkg::REG_MAX_RISE]    = 63;
        v[phsc_pkg::REG_MAX_FALL]    = 63;
        v[phsc_pkg::REG_BG_HEAT]     = 127;
        v[phsc_pkg::REG_WHITE_HOT]   = 127;
        v[phsc_pkg::REG_BASE_COLOR]  = 32'hFFFFFF;
        v[phsc_pkg::REG_NIGHT_MODE]  = 0;
        v[phsc_pkg::REG_BRIGHTNESS]  = 255;
      end
      1: begin
        v[phsc_pkg::REG_KEEP_WEIGHT] = 255;
        v[phsc_pkg::REG_MAX_RISE]    = 0;
        v[phsc_pkg::REG_MAX_FALL]    = 0;
        v[phsc_pkg::REG_BG_HEAT]     = 0;
        v[phsc_pkg::REG_WHITE_HOT]   = 0;
        v[phsc_pkg::REG_BASE_COLOR]  = 0;
        v[phsc_pkg::REG_NIGHT_MODE]  = 1;
        v[phsc_pkg::REG_BRIGHTNESS]  = 0;
      end
      2: begin
        v[phsc_pkg::REG_NIGHT_MODE] = 1;
        v[phsc_pkg::REG_BRIGHTNESS] = 40;
      end
      3: begin
        v[phsc_pkg::REG_NIGHT_MODE] = 1;
        v[phsc_pkg::REG_BRIGHTNESS] = 255;
      end
      default: ;
    endcase
    for (int r = 0; r < NUM_REGS; r++) write_knob(3'(r), v[r]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_pixel(pixel_req_t req);
    pixel_color_t due;
    int gap;
    in_valid_i       <= 1'b1;
    pixel_index_i    <= req.idx;
    glow_heat_i      <= req.heat;
    flicker_factor_i <= req.flick;
    do @(posedge clk_i); while (in_stall_o);
    due = color_pixel(req.idx, req.heat, req.flick);
    if (req.typed) begin
      due.red   = req.red;
      due.green = req.green;
      due.blue  = req.blue;
    end
    color_due.insert(color_due.size(), due);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle_stream();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (color_due.size() != 0);
  endtask

  initial begin : stimulus
    logic [31:0] rd;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    pixel_index_i    = '0;
    glow_heat_i      = '0;
    flicker_factor_i = '0;
    errors           = 0;
    cycle_count      = 0;
    tx_quiet         = 1'b1;
    rx_quiet         = 1'b0;
    long_hold_req    = 1'b0;
    burst_left       = 0;
    knobs = '{phsc_pkg::RST_KEEP_WEIGHT, phsc_pkg::RST_MAX_RISE, phsc_pkg::RST_MAX_FALL,
              phsc_pkg::RST_BG_HEAT, phsc_pkg::RST_WHITE_HOT, phsc_pkg::RST_BASE_COLOR,
              phsc_pkg::RST_NIGHT_MODE, phsc_pkg::RST_BRIGHTNESS};
    foreach (heat_level[i]) heat_level[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < NUM_REGS; r++) begin
      apb_read(3'(r), rd);
      check_field($sformatf("register %0d", r), int'(knob_value(3'(r))), int'(rd));
    end
    psel    <= 1'b0;
    penable <= 1'b0;

    foreach (PROBE_ROWS[i]) push_pixel(PROBE_ROWS[i]);

    for (int p = 0; p < PHASES; p++) begin
      settle_stream();
      program_phase(p);
      tx_quiet = (p == 4);
      rx_quiet = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // fill the pipeline against a long output hold
        if (p == 2 && n == 50) begin
          long_hold_req = 1'b1;
          burst_left    = BURST_ITEMS;
        end
        if (p == 3 && n == 90) settle_stream();
        push_pixel(random_req());
      end
    end
    settle_stream();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : rx_side
    int span;
    int roll;
    logic hold;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 1'b1;
        span = LONG_HOLD;
      end else if (rx_quiet) begin
        hold = 1'b0;
        span = 1;
      end else begin
        roll = $urandom_range(99, 0);
        if (roll < 60) begin
          hold = 1'b0;
          span = $urandom_range(8, 1);
        end else if (roll < 92) begin
          hold = 1'b1;
          span = $urandom_range(3, 1);
        end else begin
          hold = 1'b1;
          span = $urandom_range(40, 10);
        end
      end
      out_stall_i <= hold;
      repeat (span) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : color_check
    pixel_color_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (color_due.size() == 0) begin
        $error("unexpected color transaction for pixel %0d", out_index_o);
        errors++;
      end else begin
        want = color_due.pop_front();
        check_field("out_index", int'(want.idx), int'(out_index_o));
        check_field("out_red", int'(want.red), int'(out_red_o));
        check_field("out_green", int'(want.green), int'(out_green_o));
        check_field("out_blue", int'(want.blue), int'(out_blue_o));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule
